### rtl/core/bss_pkg.sv
// bss_pkg: shared constants, codes and types of the byte signature search block
// used by every module under rtl/core; depends on nothing else
`default_nettype none

package bss_pkg;

  // longest signature the cell row holds
  localparam int unsigned MAX_PATTERN = 256;
  // bits that select one cell of the row
  localparam int unsigned SEL_W       = $clog2(MAX_PATTERN);

  // fixed field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 9;
  localparam int unsigned OFF_W     = 32;
  localparam int unsigned EXT_W     = 33;
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 104;
  localparam int unsigned CFG_IDX_W = 2;

  // input kinds carried in tuser
  localparam logic KIND_SIG  = 1'b0;
  localparam logic KIND_TEXT = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_DELTA    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RETURN_DELTA   = 2'd2;

  // per-cycle control broadcast to the cell row
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // one pending result: found flag and start offset
  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] start;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/core/bss_cell.sv
// bss_cell: one cell of the match row, holding one signature byte and one window byte
// depends on bss_pkg
`default_nettype none

module bss_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bss_pkg::cell_ctrl_t         ctrl_i,
  input  wire logic                        sig_we_i,
  // this cell takes the incoming text byte
  input  wire logic                        entry_i,
  // this cell lies inside the active signature
  input  wire logic                        in_use_i,
  input  wire logic [bss_pkg::BYTE_W-1:0]  data_i,
  input  wire logic [bss_pkg::BYTE_W-1:0]  next_byte_i,
  input  wire logic                        next_vld_i,
  output logic      [bss_pkg::BYTE_W-1:0]  byte_o,
  output logic                             vld_o,
  output logic                             ok_o
);

  logic [bss_pkg::BYTE_W-1:0] sig_q;
  logic [bss_pkg::BYTE_W-1:0] win_q, win_d;
  logic                       vld_q, vld_d;

  // signature byte, written by index
  always_ff @(posedge clk_i) begin
    if (sig_we_i) begin
      sig_q <= data_i;
    end
  end

  // window byte after this transaction: new byte at the entry cell, else from the neighbor
  always_comb begin
    win_d = next_byte_i;
    vld_d = next_vld_i;
    if (entry_i) begin
      win_d = data_i;
      vld_d = 1'b1;
    end
  end

  // cell agrees when unused, or holding a real byte equal to its signature byte
  assign ok_o = ~in_use_i | (vld_d & (win_d == sig_q));

  // window byte and its valid bit, cleared at the end of a region
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      vld_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      win_q <= '0;
      vld_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      win_q <= win_d;
      vld_q <= vld_d;
    end
  end

  assign byte_o = win_q;
  assign vld_o  = vld_q;

endmodule

`default_nettype wire

### rtl/core/bss_out_buf.sv
// bss_out_buf: two-entry output buffer (head plus skid) for result transactions
// depends on bss_pkg
`default_nettype none

module bss_out_buf (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire bss_pkg::out_item_t   item_i,
  output logic                      space_o,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output bss_pkg::out_item_t        item_o
);

  logic               head_valid_q, head_valid_d;
  logic               skid_valid_q, skid_valid_d;
  bss_pkg::out_item_t head_q, head_d;
  bss_pkg::out_item_t skid_q, skid_d;
  logic               pop;

  assign pop     = head_valid_q & ready_i;
  assign space_o = ~skid_valid_q;
  assign valid_o = head_valid_q;
  assign item_o  = head_q;

  // advance on pop, then place a new item in the first free slot
  always_comb begin
    head_valid_d = head_valid_q;
    skid_valid_d = skid_valid_q;
    head_d       = head_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        head_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        head_valid_d = 1'b0;
      end
    end
    if (push_i) begin
      if (!head_valid_d) begin
        head_d       = item_i;
        head_valid_d = 1'b1;
      end else begin
        skid_d       = item_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

### rtl/core/byte_signature_search.sv
// byte_signature_search: top level, cell row, scan control and result output
// depends on bss_pkg, bss_cell and bss_out_buf
`default_nettype none

// Finds the first exact occurrence of a byte signature in a streamed region.
// A slave transaction with tuser low loads signature byte tdata[15:8] at
// position tdata[7:0]; with tuser high it streams text byte tdata[15:8],
// tlast marking the final byte of a region. Text bytes enter a row of
// MAX_PATTERN cells at cell pattern_length-1 and move one cell down per byte,
// so cell k holds the window byte lined up with signature byte k. Every cell
// compares its byte with its signature byte, and the row flags a full match
// in the cycle the byte is taken, so a signature byte rewritten mid-region is
// used from the next text byte on. One item is taken per clock while the
// two-entry output buffer has room; a result is registered there and offered
// on the master side once it reaches the head entry. The buffer lets input
// keep moving while a result waits; the input stalls only when both entries
// are full. After a match the rest of the region is dropped; a region ending
// without a match returns found low with zero offsets. Configuration must be
// written between regions, while no result is pending.
module byte_signature_search (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [bss_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [bss_pkg::BYTE_W-1:0]      cfg_data_i,
  // input stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: pattern_index [7:0], data_byte [15:8]
  input  wire logic [bss_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // tuser: kind
  input  wire logic                            s_axis_tuser,
  // tlast: last_byte
  input  wire logic                            s_axis_tlast,
  // result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // tdata: match_offset [31:0], entry_offset [64:32], return_offset [97:65], zero fill
  output logic [bss_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  // tuser: found
  output logic                                 m_axis_tuser
);

  localparam int unsigned N = bss_pkg::MAX_PATTERN;

  logic [bss_pkg::BYTE_W-1:0] pattern_length_q, entry_delta_q, return_delta_q;
  logic [bss_pkg::OFF_W-1:0]  bytes_seen_q, bytes_seen_d;
  logic                       match_done_q, match_done_d;

  logic [bss_pkg::SEL_W-1:0]  pat_idx;
  logic [bss_pkg::BYTE_W-1:0] data_byte;
  logic                       s_acc, text_acc, active;
  logic [bss_pkg::LEN_W-1:0]  len_raw, len;
  logic [bss_pkg::SEL_W-1:0]  sel;
  logic                       match, produce;

  bss_pkg::cell_ctrl_t                    cell_ctrl;
  logic [N-1:0][bss_pkg::BYTE_W-1:0]      win_q;
  logic [N-1:0]                           vld_q;
  logic [N-1:0]                           cell_ok;
  logic                       buf_space;
  bss_pkg::out_item_t         new_item, head_item;
  logic [bss_pkg::EXT_W-1:0]  entry_off, return_off;

  assign pat_idx   = s_axis_tdata[bss_pkg::SEL_W-1:0];
  assign data_byte = s_axis_tdata[15:8];
  assign s_axis_tready = buf_space;
  assign s_acc    = s_axis_tvalid & s_axis_tready;
  assign text_acc = s_acc & (s_axis_tuser == bss_pkg::KIND_TEXT);
  assign active   = text_acc & ~match_done_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_length_q <= 8'd1;
      entry_delta_q    <= '0;
      return_delta_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bss_pkg::REG_PATTERN_LENGTH: pattern_length_q <= cfg_data_i;
        bss_pkg::REG_ENTRY_DELTA:    entry_delta_q    <= cfg_data_i;
        bss_pkg::REG_RETURN_DELTA:   return_delta_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // active length, zero taken as one and clamped to the row size
  always_comb begin
    len_raw = {1'b0, pattern_length_q};
    if (len_raw == '0) begin
      len_raw = bss_pkg::LEN_W'(1);
    end
    len = len_raw;
    if (len_raw > bss_pkg::LEN_W'(N)) begin
      len = bss_pkg::LEN_W'(N);
    end
  end
  assign sel = bss_pkg::SEL_W'(len - bss_pkg::LEN_W'(1));

  // cell row control
  assign cell_ctrl.shift = active;
  assign cell_ctrl.clear = text_acc & s_axis_tlast;

  // row of window cells, each fed by its upper neighbor
  for (genvar k = 0; k < N; k++) begin : g_cell
    logic [bss_pkg::BYTE_W-1:0] next_byte;
    logic                       next_vld;
    logic                       sig_we;
    logic                       entry;
    logic                       in_use;
    if (k == N - 1) begin : g_top
      assign next_byte = '0;
      assign next_vld  = 1'b0;
    end else begin : g_rest
      assign next_byte = win_q[k+1];
      assign next_vld  = vld_q[k+1];
    end
    assign sig_we = s_acc & (s_axis_tuser == bss_pkg::KIND_SIG) &
                    (pat_idx == bss_pkg::SEL_W'(k));
    assign entry  = (sel == bss_pkg::SEL_W'(k));
    assign in_use = (bss_pkg::SEL_W'(k) <= sel);
    bss_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .sig_we_i   (sig_we),
      .entry_i    (entry),
      .in_use_i   (in_use),
      .data_i     (data_byte),
      .next_byte_i(next_byte),
      .next_vld_i (next_vld),
      .byte_o     (win_q[k]),
      .vld_o      (vld_q[k]),
      .ok_o       (cell_ok[k])
    );
  end

  // full match when every cell of the signature agrees
  assign match   = &cell_ok;
  assign produce = active & (match | s_axis_tlast);

  assign new_item.found = match;
  assign new_item.start = match ?
      (bytes_seen_q - bss_pkg::OFF_W'(len) + bss_pkg::OFF_W'(1)) : '0;

  // scan position and done flag
  always_comb begin
    bytes_seen_d = bytes_seen_q;
    match_done_d = match_done_q;
    if (active) begin
      bytes_seen_d = bytes_seen_q + bss_pkg::OFF_W'(1);
      if (match) begin
        match_done_d = 1'b1;
      end
    end
    if (text_acc & s_axis_tlast) begin
      bytes_seen_d = '0;
      match_done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_seen_q <= '0;
      match_done_q <= 1'b0;
    end else begin
      bytes_seen_q <= bytes_seen_d;
      match_done_q <= match_done_d;
    end
  end

  bss_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s_acc & produce),
    .item_i (new_item),
    .space_o(buf_space),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .item_o (head_item)
  );

  // entry and return points from the held start offset
  assign entry_off  = head_item.found ?
      ({1'b0, head_item.start} + bss_pkg::EXT_W'(entry_delta_q)) : '0;
  assign return_off = head_item.found ?
      ({1'b0, head_item.start} + bss_pkg::EXT_W'(return_delta_q)) : '0;

  assign m_axis_tuser = head_item.found;
  assign m_axis_tdata = {6'b0, return_off, entry_off, head_item.start};

endmodule

`default_nettype wire

### rtl/core/bss_checker.sv
// bss_checker: port-level assertions for byte_signature_search, with its bind
// depends on bss_pkg and the byte_signature_search ports
`default_nettype none

module bss_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  input  wire logic                            s_axis_tready,
  input  wire logic                            s_axis_tuser,
  input  wire logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  input  wire logic [bss_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input  wire logic                            m_axis_tuser
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a not-found result carries zero offsets
  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[97:0] == '0)
    else $error("not-found result with nonzero offsets");

  // entry and return points never lie before the match
  a_offsets_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      ({1'b0, m_axis_tdata[31:0]} <= m_axis_tdata[64:32]) &&
      ({1'b0, m_axis_tdata[31:0]} <= m_axis_tdata[97:65]))
    else $error("entry or return point before match offset");

  // a signature load never yields a result on the next cycle from an idle block
  a_sig_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && s_axis_tvalid && s_axis_tready &&
      (s_axis_tuser == bss_pkg::KIND_SIG) |=> !m_axis_tvalid)
    else $error("result after signature load");

endmodule

bind byte_signature_search bss_checker u_bss_checker (.*);

`default_nettype wire

### tb/tb_byte_signature_search.sv
// tb_byte_signature_search: self-checking bench for the byte signature search block
// depends on bss_pkg and byte_signature_search; predicts results with its own window model
`timescale 1ns / 1ps

module tb_byte_signature_search;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned WIN_BITS    = bss_pkg::MAX_PATTERN * bss_pkg::BYTE_W;

  // one input transaction as the bench sees it
  typedef struct packed {
    logic             kind;
    logic [7:0]       idx;
    logic [7:0]       data;
    logic             last;
  } stream_item_t;

  // one result transaction
  typedef struct packed {
    logic                      found;
    logic [bss_pkg::OFF_W-1:0] match_off;
    logic [bss_pkg::EXT_W-1:0] entry_off;
    logic [bss_pkg::EXT_W-1:0] ret_off;
  } scan_result_t;

  // dut ports, the inputs all known from time zero
  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_we_i      = 1'b0;
  logic [bss_pkg::CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [bss_pkg::BYTE_W-1:0]      cfg_data_i    = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // tdata: pattern_index [7:0], data_byte [15:8]
  logic [bss_pkg::S_TDATA_W-1:0]   s_axis_tdata  = '0;
  // tuser: kind
  logic                            s_axis_tuser  = 1'b0;
  // tlast: last_byte
  logic                            s_axis_tlast  = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // tdata: match_offset [31:0], entry_offset [64:32], return_offset [97:65], zero fill
  logic [bss_pkg::M_TDATA_W-1:0]   m_axis_tdata;
  // tuser: found
  logic                            m_axis_tuser;

  // register shadow, written only while the block is idle
  logic [7:0]             cfg_len   = 8'd1;
  logic [7:0]             cfg_entry = 8'd0;
  logic [7:0]             cfg_ret   = 8'd0;

  // search state of the prediction side
  logic [7:0]                sig_mem [0:bss_pkg::MAX_PATTERN-1];
  logic [WIN_BITS-1:0]       text_win  = '0;
  int unsigned               win_fill  = 0;
  logic [bss_pkg::OFF_W-1:0] bytes_seen = '0;
  bit                        region_hit = 1'b0;

  // stimulus side view of the signature
  logic [7:0]             gen_sig [0:bss_pkg::MAX_PATTERN-1];
  logic [7:0]             gen_alpha [0:1];

  stream_item_t           stim_q[$];
  scan_result_t           result_q[$];

  int unsigned            items_queued = 0;
  int unsigned            items_taken  = 0;
  int unsigned            n_loads = 0, n_text = 0, n_regions = 0;
  int unsigned            n_found = 0, n_miss = 0, n_settings = 0;
  int unsigned            n_errors = 0;
  int unsigned            cycles = 0;
  int unsigned            send_idle_pct = 0;
  int unsigned            recv_idle_pct = 0;
  int unsigned            send_gap = 0;
  int unsigned            recv_stall = 0;
  bit                     in_took = 1'b0;

  byte_signature_search uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_idle(input int unsigned pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // one accepted transaction through the search model
  task automatic scan_step(input stream_item_t it);
    int unsigned  len;
    bit           hit;
    scan_result_t r;
    r = '0;
    if (it.kind == bss_pkg::KIND_SIG) begin
      sig_mem[it.idx] = it.data;
      n_loads++;
      return;
    end
    n_text++;
    if (!region_hit) begin
      len = (cfg_len == 0) ? 1 : cfg_len;
      text_win = {text_win[WIN_BITS-9:0], it.data};
      if (win_fill < bss_pkg::MAX_PATTERN) win_fill++;
      // newest byte sits in the low byte of the window
      hit = (win_fill >= len);
      for (int k = 0; k < len && hit; k++) begin
        if (sig_mem[k] != text_win[(len-1-k)*8 +: 8]) hit = 1'b0;
      end
      if (hit) begin
        r.found     = 1'b1;
        r.match_off = bytes_seen - (len - 1);
        r.entry_off = {1'b0, r.match_off} + {25'd0, cfg_entry};
        r.ret_off   = {1'b0, r.match_off} + {25'd0, cfg_ret};
        result_q.push_back(r);
        region_hit = 1'b1;
        n_found++;
      end
      bytes_seen = bytes_seen + 1;
    end
    if (it.last) begin
      if (!region_hit) begin
        result_q.push_back(r);
        n_miss++;
      end
      n_regions++;
      text_win   = '0;
      win_fill   = 0;
      bytes_seen = '0;
      region_hit = 1'b0;
    end
  endtask

  // monitor: check results, then predict from the accepted input
  always @(posedge clk_i) begin : monitor
    scan_result_t exp_r;
    stream_item_t it;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          $error("result transaction with nothing expected: found %0b match %0h",
                 m_axis_tuser, m_axis_tdata[31:0]);
          n_errors++;
        end else begin
          exp_r = result_q.pop_front();
          if (m_axis_tuser !== exp_r.found) begin
            $error("found: expected %0h actual %0h", exp_r.found, m_axis_tuser);
            n_errors++;
          end
          if (m_axis_tdata[31:0] !== exp_r.match_off) begin
            $error("match_offset: expected %0h actual %0h",
                   exp_r.match_off, m_axis_tdata[31:0]);
            n_errors++;
          end
          if (m_axis_tdata[64:32] !== exp_r.entry_off) begin
            $error("entry_offset: expected %0h actual %0h",
                   exp_r.entry_off, m_axis_tdata[64:32]);
            n_errors++;
          end
          if (m_axis_tdata[97:65] !== exp_r.ret_off) begin
            $error("return_offset: expected %0h actual %0h",
                   exp_r.ret_off, m_axis_tdata[97:65]);
            n_errors++;
          end
        end
      end
      in_took = s_axis_tvalid && s_axis_tready;
      if (in_took) begin
        it.kind = s_axis_tuser;
        it.idx  = s_axis_tdata[7:0];
        it.data = s_axis_tdata[15:8];
        it.last = s_axis_tlast;
        scan_step(it);
        items_taken++;
      end
    end
  end

  // driver: feed pending items with random gaps, change on the falling edge
  always @(negedge clk_i) begin : driver
    stream_item_t it;
    logic         v;
    v = s_axis_tvalid;
    if (rst_ni && !(s_axis_tvalid && !in_took)) begin
      if (send_gap > 0) begin
        send_gap--;
        v = 1'b0;
      end else if (stim_q.size() > 0) begin
        it = stim_q.pop_front();
        v  = 1'b1;
        s_axis_tuser <= it.kind;
        s_axis_tdata <= {it.data, it.idx};
        s_axis_tlast <= it.last;
        send_gap = pick_idle(send_idle_pct);
      end else begin
        v = 1'b0;
      end
    end
    s_axis_tvalid <= v;
  end

  // result side back-pressure
  always @(negedge clk_i) begin : receiver
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      recv_stall = pick_idle(recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_byte_signature_search: FAIL");
      $finish;
    end
  end

  task automatic queue_item(input logic kind, input logic [7:0] idx,
                            input logic [7:0] data, input logic last);
    stream_item_t it;
    it.kind = kind;
    it.idx  = idx;
    it.data = data;
    it.last = last;
    if (kind == bss_pkg::KIND_SIG) gen_sig[idx] = data;
    stim_q.push_back(it);
    items_queued++;
  endtask

  // load signature bytes 0..count-1 from the phase alphabet or the full range
  task automatic load_signature(input int unsigned count, input bit wide);
    for (int k = 0; k < count; k++) begin
      queue_item(bss_pkg::KIND_SIG, k[7:0],
                 wide ? 8'($urandom_range(0, 255)) : gen_alpha[$urandom_range(0, 1)],
                 1'($urandom_range(0, 1)));
    end
  endtask

  // one region ending in a last byte, optionally with the signature or a prefix planted
  task automatic queue_region(input bit plant, input bit wide,
                              input int unsigned n_min, input int unsigned n_max);
    logic [7:0]  buffer [0:511];
    int unsigned eff, n, pos, cut;
    eff = (cfg_len == 0) ? 1 : cfg_len;
    n   = $urandom_range(n_min, n_max) + (plant ? eff : 0);
    for (int i = 0; i < n; i++) begin
      buffer[i] = wide ? 8'($urandom_range(0, 255)) : gen_alpha[$urandom_range(0, 1)];
    end
    if (plant) begin
      pos = $urandom_range(0, n - eff);
      // a quarter are broken: only a prefix of the signature
      cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, eff - 1) : eff;
      for (int k = 0; k < cut; k++) buffer[pos+k] = gen_sig[k];
    end
    for (int i = 0; i < n; i++) begin
      // rare signature rewrite in the middle of a region
      if ($urandom_range(0, 49) == 0) begin
        queue_item(bss_pkg::KIND_SIG, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      queue_item(bss_pkg::KIND_TEXT, 8'($urandom_range(0, 255)), buffer[i], i == n - 1);
    end
  endtask

  // sender pause: everything taken and every result back, then the latency tail
  task automatic wait_idle();
    while (items_taken != items_queued || result_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [bss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      bss_pkg::REG_PATTERN_LENGTH: cfg_len   = val;
      bss_pkg::REG_ENTRY_DELTA:    cfg_entry = val;
      bss_pkg::REG_RETURN_DELTA:   cfg_ret   = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(input logic [7:0] len, input logic [7:0] ed, input logic [7:0] rd);
    write_reg(bss_pkg::REG_PATTERN_LENGTH, len);
    write_reg(bss_pkg::REG_ENTRY_DELTA, ed);
    write_reg(bss_pkg::REG_RETURN_DELTA, rd);
    n_settings++;
  endtask

  // stimulus and end of run
  initial begin : stimulus
    int unsigned phase_start, r, plen;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: three byte signature with extreme bytes
    set_regs(8'd3, 8'd0, 8'd255);
    queue_item(bss_pkg::KIND_SIG, 8'd0, 8'hA5, 1'b0);
    queue_item(bss_pkg::KIND_SIG, 8'd1, 8'h00, 1'b0);
    queue_item(bss_pkg::KIND_SIG, 8'd2, 8'hFF, 1'b0);
    // load with last mark, top index
    queue_item(bss_pkg::KIND_SIG, 8'd255, 8'h5A, 1'b1);
    // match mid-region, following bytes and last byte give nothing
    queue_item(bss_pkg::KIND_TEXT, 8'd0, 8'h11, 1'b0);
    queue_item(bss_pkg::KIND_TEXT, 8'd255, 8'hA5, 1'b0);
    queue_item(bss_pkg::KIND_TEXT, 8'd0, 8'h00, 1'b0);
    queue_item(bss_pkg::KIND_TEXT, 8'd0, 8'hFF, 1'b0);
    queue_item(bss_pkg::KIND_TEXT, 8'd0, 8'h22, 1'b1);
    // region shorter than the signature
    queue_item(bss_pkg::KIND_TEXT, 8'd0, 8'hA5, 1'b0);
    queue_item(bss_pkg::KIND_TEXT, 8'd0, 8'h00, 1'b1);
    // match on the last byte
    queue_item(bss_pkg::KIND_TEXT, 8'd0, 8'hA5, 1'b0);
    queue_item(bss_pkg::KIND_TEXT, 8'd0, 8'h00, 1'b0);
    queue_item(bss_pkg::KIND_TEXT, 8'd0, 8'hFF, 1'b1);
    // single byte region
    queue_item(bss_pkg::KIND_TEXT, 8'd0, 8'hFF, 1'b1);
    wait_idle();

    // zero length acts as one; largest entry delta
    set_regs(8'd0, 8'd255, 8'd128);
    queue_item(bss_pkg::KIND_SIG, 8'd0, 8'h00, 1'b0);
    queue_item(bss_pkg::KIND_TEXT, 8'd0, 8'hFF, 1'b0);
    queue_item(bss_pkg::KIND_TEXT, 8'd0, 8'h00, 1'b1);
    queue_item(bss_pkg::KIND_TEXT, 8'd0, 8'hFF, 1'b1);
    wait_idle();

    // longest lengths, window filled past its depth
    send_idle_pct = 20;
    recv_idle_pct = 20;
    set_regs(8'd255, 8'd1, 8'd254);
    load_signature(255, 1'b1);
    queue_region(1'b1, 1'b1, 5, 20);
    wait_idle();
    set_regs(8'd254, 8'd255, 8'd255);
    queue_region(1'b1, 1'b1, 0, 2);
    wait_idle();

    // random phases
    for (int p = 0; p < 8; p++) begin
      r = $urandom_range(0, 9);
      if (r < 5) plen = $urandom_range(1, 4);
      else if (r < 8) plen = $urandom_range(5, 12);
      else if (r < 9) plen = $urandom_range(13, 40);
      else plen = 0;
      // first phase runs without any idling
      send_idle_pct = (p == 0) ? 0 : 30 * $urandom_range(0, 2);
      recv_idle_pct = (p == 0) ? 0 : 30 * $urandom_range(0, 2);
      gen_alpha[0] = 8'($urandom_range(0, 255));
      gen_alpha[1] = gen_alpha[0] ^ (8'd1 << $urandom_range(0, 7));
      set_regs(8'(plen), ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(0, 255)),
               ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255)));
      load_signature((plen == 0) ? 1 : plen, 1'($urandom_range(0, 3) == 0));
      phase_start = items_queued;
      while (items_queued - phase_start < 60) begin
        r = $urandom_range(0, 9);
        if (r < 6) queue_region(1'b1, 1'b0, 0, 24);
        else if (r < 8) queue_region(1'b1, 1'b1, 0, 24);
        else if (r < 9) queue_region(1'b0, 1'b1, 1, 32);
        else queue_region(1'b0, 1'b0, 1, 32);
      end
      wait_idle();
    end

    $display("covered %0d signature loads and %0d text bytes in %0d regions over %0d settings",
             n_loads, n_text, n_regions, n_settings);
    $display("checked %0d matches and %0d regions without a match", n_found, n_miss);
    if (n_errors == 0) begin
      $display("tb_byte_signature_search: PASS");
    end else begin
      $display("tb_byte_signature_search: FAIL");
    end
    $finish;
  end

endmodule
